// ===== rtl/wac_pkg.sv =====
// Shared types and constants for the windowed activity classifier.
package wac_pkg;

  localparam int unsigned MAG_W     = 16;
  localparam int unsigned WLEN_W    = 9;
  localparam int unsigned VAR_W     = 32;
  localparam int unsigned STEP_W    = 32;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  // Centered-sample level for step detection, one bit wider than a sample.
  localparam logic [MAG_W:0] STEP_LEVEL = 17'd200;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL_MAX     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WALK_MAX      = 2'd2;

  localparam logic [WLEN_W-1:0] WLEN_RESET  = 9'd100;
  localparam logic [VAR_W-1:0]  STILL_RESET = 32'd10000;
  localparam logic [VAR_W-1:0]  WALK_RESET  = 32'd250000;

  typedef enum logic [ACT_W-1:0] {
    ACT_STILL = 2'd0,
    ACT_WALK  = 2'd1,
    ACT_RUN   = 2'd2
  } activity_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SWEEP,
    ST_DRAIN,
    ST_MUL1,
    ST_MUL2,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic sweep;
    logic mul1;
    logic mul2;
    logic decide;
    logic fill_emit;
    logic full_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fill_mode;
    logic sweep_last;
    logic pipe_busy;
  } dp_status_t;

endpackage

// ===== rtl/wac_ctrl.sv =====
// Sequencer for the classifier: item handshake, window sweep and arithmetic steps.
module wac_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  wac_pkg::dp_status_t status,
  output wac_pkg::ctrl_cmd_t  cmd
);

  wac_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  // Output slot can take a new item if empty or being drained this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != wac_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wac_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.fill_mode ? wac_pkg::ST_FILL : wac_pkg::ST_SWEEP;
        end
      end
      wac_pkg::ST_FILL: begin
        if (out_free) begin
          state_nxt = wac_pkg::ST_IDLE;
        end
      end
      wac_pkg::ST_SWEEP: begin
        if (status.sweep_last) begin
          state_nxt = wac_pkg::ST_DRAIN;
        end
      end
      wac_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = wac_pkg::ST_MUL1;
        end
      end
      wac_pkg::ST_MUL1:   state_nxt = wac_pkg::ST_MUL2;
      wac_pkg::ST_MUL2:   state_nxt = wac_pkg::ST_DECIDE;
      wac_pkg::ST_DECIDE: state_nxt = wac_pkg::ST_EMIT;
      wac_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = wac_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state_r == wac_pkg::ST_IDLE) && in_valid;
    cmd.sweep     = (state_r == wac_pkg::ST_SWEEP);
    cmd.mul1      = (state_r == wac_pkg::ST_MUL1);
    cmd.mul2      = (state_r == wac_pkg::ST_MUL2);
    cmd.decide    = (state_r == wac_pkg::ST_DECIDE);
    cmd.fill_emit = (state_r == wac_pkg::ST_FILL) && out_free;
    cmd.full_emit = (state_r == wac_pkg::ST_EMIT) && out_free;
  end

  always_comb begin
    if (cmd.fill_emit || cmd.full_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wac_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/wac_dp.sv =====
// Datapath: window store, sum and square-sum sweep, variance and step logic.
module wac_dp #(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  wac_pkg::ctrl_cmd_t                     cmd,
  output wac_pkg::dp_status_t                    status,
  input  logic [wac_pkg::MAG_W-1:0]              in_magnitude,
  input  logic                                   cfg_we,
  input  logic [wac_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [wac_pkg::CFG_W-1:0]              cfg_wdata,
  output logic                                   out_label_valid,
  output logic [wac_pkg::ACT_W-1:0]              out_activity,
  output logic [wac_pkg::STEP_W-1:0]             out_step_total
);

  localparam int unsigned AW   = $clog2(MAX_WINDOW);
  localparam int unsigned WW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned MW   = wac_pkg::MAG_W;
  localparam int unsigned SW   = MW + WW;
  localparam int unsigned QW   = 2 * MW + WW;
  localparam int unsigned CW   = wac_pkg::VAR_W + 2 * WW;
  localparam int unsigned WM_W = WW + MW + 1;

  // Configuration registers
  logic [wac_pkg::WLEN_W-1:0] wlen_r;
  logic [wac_pkg::VAR_W-1:0]  still_max_r;
  logic [wac_pkg::VAR_W-1:0]  walk_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r      <= wac_pkg::WLEN_RESET;
      still_max_r <= wac_pkg::STILL_RESET;
      walk_max_r  <= wac_pkg::WALK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wac_pkg::CFG_WINDOW_LENGTH: wlen_r      <= cfg_wdata[wac_pkg::WLEN_W-1:0];
        wac_pkg::CFG_STILL_MAX:     still_max_r <= cfg_wdata[wac_pkg::VAR_W-1:0];
        wac_pkg::CFG_WALK_MAX:      walk_max_r  <= cfg_wdata[wac_pkg::VAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective window: zero reads as one, oversize clamps to the store depth.
  logic [WW-1:0] w;
  always_comb begin
    if (wlen_r == '0) begin
      w = WW'(1);
    end else if (32'(wlen_r) > 32'(MAX_WINDOW)) begin
      w = WW'(MAX_WINDOW);
    end else begin
      w = WW'(wlen_r);
    end
  end

  // Item state
  logic [MW-1:0]             mag_r;
  logic [WW-1:0]             fill_count_r;
  logic                      primed_r;
  logic                      was_below_r;
  logic [wac_pkg::STEP_W-1:0] step_counter_r;

  // Sweep pipeline
  logic [AW-1:0]  idx_r;
  logic [WW-1:0]  idx_w;
  logic [WW-1:0]  idx_next_w;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [MW-1:0]  rd_data_r;
  logic           b_valid_r;
  logic [AW-1:0]  b_idx_r;
  logic           b_last_r;
  logic [MW-1:0]  b_v;
  logic           c_valid_r;
  logic [MW-1:0]  c_v_r;
  logic [2*MW-1:0] c_sq_r;
  logic [SW-1:0]  sum_r;
  logic [QW-1:0]  sq_r;

  // Final arithmetic
  logic [CW-1:0]   wq_r;
  logic [CW-1:0]   ss_r;
  logic [2*WW-1:0] ww_r;
  logic [WM_W-1:0] wm_r;
  logic [CW-1:0]   spread_r;
  logic [CW-1:0]   t_still_r;
  logic [CW-1:0]   t_walk_r;
  wac_pkg::activity_t label_r;
  logic            below;

  // Output payload
  logic                       out_label_valid_r;
  wac_pkg::activity_t         out_activity_r;
  logic [wac_pkg::STEP_W-1:0] out_step_total_r;

  // Window store
  logic [MW-1:0] mem [MAX_WINDOW];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;

  assign idx_w      = WW'(idx_r);
  assign idx_next_w = idx_w + WW'(1);
  assign rd_en      = cmd.sweep && (idx_next_w < w);
  assign rd_addr    = idx_next_w[AW-1:0];

  // Element idx takes old entry idx+1; the last element takes the new sample.
  assign b_v = b_last_r ? mag_r : rd_data_r;

  always_comb begin
    if (cmd.fill_emit) begin
      mem_we    = 1'b1;
      mem_waddr = fill_count_r[AW-1:0];
      mem_wdata = mag_r;
    end else begin
      mem_we    = b_valid_r;
      mem_waddr = b_idx_r;
      mem_wdata = b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign status.fill_mode  = (fill_count_r < w);
  assign status.sweep_last = (idx_w == (w - WW'(1)));
  assign status.pipe_busy  = b_valid_r || c_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      b_valid_r <= cmd.sweep;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mag_r <= in_magnitude;
      idx_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
    end else begin
      if (cmd.sweep) begin
        idx_r <= idx_r + AW'(1);
      end
      if (c_valid_r) begin
        sum_r <= sum_r + SW'(c_v_r);
        sq_r  <= sq_r + QW'(c_sq_r);
      end
    end
    if (cmd.sweep) begin
      b_idx_r  <= idx_r;
      b_last_r <= status.sweep_last;
    end
    c_v_r  <= b_v;
    c_sq_r <= (2*MW)'(b_v) * (2*MW)'(b_v);
  end

  // W*Q - S*S against T*W*W; W*(x + level) against S for the step detector.
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      wq_r <= CW'(w) * CW'(sq_r);
      ss_r <= CW'(sum_r) * CW'(sum_r);
      ww_r <= (2*WW)'(w) * (2*WW)'(w);
      wm_r <= WM_W'(w) * WM_W'({1'b0, mag_r} + wac_pkg::STEP_LEVEL);
    end
    if (cmd.mul2) begin
      spread_r  <= wq_r - ss_r;
      t_still_r <= CW'(still_max_r) * CW'(ww_r);
      t_walk_r  <= CW'(walk_max_r) * CW'(ww_r);
    end
    if (cmd.decide) begin
      if (spread_r < t_still_r) begin
        label_r <= wac_pkg::ACT_STILL;
      end else if (spread_r < t_walk_r) begin
        label_r <= wac_pkg::ACT_WALK;
      end else begin
        label_r <= wac_pkg::ACT_RUN;
      end
    end
  end

  assign below = wm_r < WM_W'(sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r   <= '0;
      primed_r       <= 1'b0;
      was_below_r    <= 1'b0;
      step_counter_r <= '0;
    end else begin
      if (cmd.fill_emit) begin
        fill_count_r <= fill_count_r + WW'(1);
      end
      if (cmd.decide) begin
        if (primed_r && was_below_r && !below) begin
          step_counter_r <= step_counter_r + wac_pkg::STEP_W'(1);
        end
        primed_r    <= 1'b1;
        was_below_r <= below;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_emit) begin
      out_label_valid_r <= 1'b0;
      out_activity_r    <= wac_pkg::ACT_STILL;
      out_step_total_r  <= step_counter_r;
    end else if (cmd.full_emit) begin
      out_label_valid_r <= 1'b1;
      out_activity_r    <= label_r;
      out_step_total_r  <= step_counter_r;
    end
  end

  assign out_label_valid = out_label_valid_r;
  assign out_activity    = out_activity_r;
  assign out_step_total  = out_step_total_r;

endmodule

// ===== rtl/windowed_activity_classifier.sv =====
// Windowed activity classifier: accepts one magnitude sample per item and returns one
// result item per sample. While the window fills (the first W samples, W =
// window_length clamped to 1..MAX_WINDOW) an item reports no label. Once full, each
// item sweeps the window: the store has a single read port and is shifted one entry
// per cycle while the sum and square sum are rebuilt, followed by a pipeline drain,
// two multiply steps, a compare and the output load. Output stalls lengthen an item.
// A new sample is taken while the previous result is still waiting at the output.
// The user must write registers only while idle; the block does not enforce it.
module windowed_activity_classifier #(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [wac_pkg::MAG_W-1:0]             in_magnitude,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_label_valid,
  output logic [wac_pkg::ACT_W-1:0]             out_activity,
  output logic [wac_pkg::STEP_W-1:0]            out_step_total,
  input  logic                                  cfg_we,
  input  logic [wac_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wac_pkg::CFG_W-1:0]             cfg_wdata
);

  wac_pkg::ctrl_cmd_t  cmd;
  wac_pkg::dp_status_t status;

  wac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  wac_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_magnitude    (in_magnitude),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_label_valid (out_label_valid),
    .out_activity    (out_activity),
    .out_step_total  (out_step_total)
  );

endmodule

// ===== test/windowed_activity_classifier_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the windowed activity classifier: predicts and compares every result item.
module windowed_activity_classifier_checker
  import wac_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [MAG_W-1:0]     in_magnitude,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_label_valid,
  input  logic [ACT_W-1:0]     out_activity,
  input  logic [STEP_W-1:0]    out_step_total,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   pending,
  output int                   still_seen,
  output int                   walk_seen,
  output int                   run_seen,
  output logic [STEP_W-1:0]    last_step_total
);

  typedef struct packed {
    logic              label_valid;
    activity_t         activity;
    logic [STEP_W-1:0] step_total;
  } label_item_t;

  // Predicted block state
  logic [MAG_W-1:0]  window_q [MAX_WINDOW];
  int unsigned       fill_cnt;
  logic              was_below;
  logic              primed;
  logic [STEP_W-1:0] step_cnt;
  logic [WLEN_W-1:0] wlen;
  logic [VAR_W-1:0]  still_max;
  logic [VAR_W-1:0]  walk_max;

  label_item_t expected_labels [$];
  int          err_cnt;
  int          n_still;
  int          n_walk;
  int          n_run;

  function automatic label_item_t classify_sample(input logic [MAG_W-1:0] mag);
    label_item_t res;
    int unsigned w;
    int unsigned i;
    logic [63:0] sum;
    logic [63:0] sq;
    logic [63:0] spread;
    logic [63:0] ww;
    logic        below_now;
    w = (wlen == 0) ? 1 : ((wlen > MAX_WINDOW) ? MAX_WINDOW : wlen);
    if (fill_cnt < w) begin
      window_q[fill_cnt] = mag;
      fill_cnt++;
      res.label_valid = 1'b0;
      res.activity    = ACT_STILL;
      res.step_total  = step_cnt;
      return res;
    end
    for (i = 1; i < w; i++) window_q[i-1] = window_q[i];
    window_q[w-1] = mag;
    sum = '0;
    sq  = '0;
    for (i = 0; i < w; i++) begin
      sum += 64'(window_q[i]);
      sq  += 64'(window_q[i]) * 64'(window_q[i]);
    end
    // variance compares scaled by W*W so everything stays integer
    spread = 64'(w) * sq - sum * sum;
    ww     = 64'(w) * 64'(w);
    if (spread < 64'(still_max) * ww) res.activity = ACT_STILL;
    else if (spread < 64'(walk_max) * ww) res.activity = ACT_WALK;
    else res.activity = ACT_RUN;
    below_now = (64'(w) * 64'(mag) + 64'(STEP_LEVEL) * 64'(w)) < sum;
    if (primed && was_below && !below_now) step_cnt++;
    primed    = 1'b1;
    was_below = below_now;
    res.label_valid = 1'b1;
    res.step_total  = step_cnt;
    return res;
  endfunction

  always @(posedge clk) begin : track
    label_item_t want;
    if (!rst_n) begin
      wlen      = WLEN_RESET;
      still_max = STILL_RESET;
      walk_max  = WALK_RESET;
      fill_cnt  = 0;
      was_below = 1'b0;
      primed    = 1'b0;
      step_cnt  = '0;
      expected_labels.delete();
      err_cnt = 0;
      n_still = 0;
      n_walk  = 0;
      n_run   = 0;
      last_step_total <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_LENGTH: wlen = cfg_wdata[WLEN_W-1:0];
          CFG_STILL_MAX:     still_max = cfg_wdata[VAR_W-1:0];
          CFG_WALK_MAX:      walk_max = cfg_wdata[VAR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_labels.size() == 0) begin
          $error("result item with nothing expected: label_valid %0d activity %0d steps %0d",
                 out_label_valid, out_activity, out_step_total);
          err_cnt++;
        end else begin
          want = expected_labels.pop_front();
          if (out_label_valid !== want.label_valid) begin
            $error("label_valid: expected %0d, actual %0d", want.label_valid, out_label_valid);
            err_cnt++;
          end
          if (out_activity !== want.activity) begin
            $error("activity: expected %0d, actual %0d", want.activity, out_activity);
            err_cnt++;
          end
          if (out_step_total !== want.step_total) begin
            $error("step_total: expected %0d, actual %0d", want.step_total, out_step_total);
            err_cnt++;
          end
          if (want.label_valid) begin
            case (want.activity)
              ACT_STILL: n_still++;
              ACT_WALK:  n_walk++;
              default:   n_run++;
            endcase
          end
          last_step_total <= want.step_total;
        end
      end
      if (in_valid && !in_stall) expected_labels.push_back(classify_sample(in_magnitude));
    end
    mismatches <= err_cnt;
    pending    <= expected_labels.size();
    still_seen <= n_still;
    walk_seen  <= n_walk;
    run_seen   <= n_run;
  end

endmodule

// ===== test/windowed_activity_classifier_test.sv =====
`timescale 1ns / 1ps
// Top of the windowed activity classifier test: stimulus, handshake idling and the verdict.
module windowed_activity_classifier_test;
  import wac_pkg::*;

  localparam int unsigned MAX_WINDOW     = 256;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          SETTLE_CYCLES  = 300;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [MAG_W-1:0]     in_magnitude = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_label_valid;
  logic [ACT_W-1:0]     out_activity;
  logic [STEP_W-1:0]    out_step_total;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW_LENGTH;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int                mismatches;
  int                pending;
  int                still_seen;
  int                walk_seen;
  int                run_seen;
  logic [STEP_W-1:0] last_step_total;

  logic calm = 1'b0;    // no gaps and no stalls while set
  int   idle_cycles = 0;
  int   samples_sent = 0;
  int   settings_used = 0;

  // gait waveform generator state
  int gait_base;
  int gait_amp;
  int gait_period;
  int gait_noise;
  int gait_t;
  int noise_pct;

  windowed_activity_classifier #(.MAX_WINDOW(MAX_WINDOW)) dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_magnitude,
    .out_valid, .out_stall, .out_label_valid, .out_activity, .out_step_total,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  windowed_activity_classifier_checker #(.MAX_WINDOW(MAX_WINDOW)) label_check (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_magnitude,
    .out_valid, .out_stall, .out_label_valid, .out_activity, .out_step_total,
    .cfg_we, .cfg_index, .cfg_wdata,
    .mismatches, .pending, .still_seen, .walk_seen, .run_seen, .last_step_total
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int unsigned run_len;
    int unsigned stall_len;
    int unsigned r;
    @(posedge clk);
    forever begin
      out_stall <= 1'b0;
      run_len = $urandom_range(8, 1);
      repeat (run_len) @(posedge clk);
      r = $urandom_range(99);
      if (calm || r < 55) stall_len = 0;
      else if (r < 88) stall_len = $urandom_range(3, 1);
      else if (r < 97) stall_len = $urandom_range(15, 4);
      else stall_len = $urandom_range(120, 30);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void new_gait();
    gait_base   = $urandom_range(3000, 200);
    gait_amp    = ($urandom_range(3) == 0) ? $urandom_range(30) : $urandom_range(3000);
    gait_period = $urandom_range(12, 2);
    gait_noise  = $urandom_range(50);
    gait_t      = $urandom_range(gait_period);
    noise_pct   = $urandom_range(20, 5);
  endfunction

  // Mostly a square-wave gait around a base level, with some full-range noise and extremes.
  function automatic logic [MAG_W-1:0] next_magnitude();
    int          v;
    int unsigned r;
    r = $urandom_range(99);
    if (r < noise_pct) return MAG_W'($urandom());
    if (r < noise_pct + 2) return {MAG_W{r[0]}};
    gait_t++;
    v = gait_base + (((gait_t % gait_period) < gait_period / 2) ? gait_amp : -gait_amp);
    v += $urandom_range(gait_noise);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return MAG_W'(v);
  endfunction

  function automatic logic [VAR_W-1:0] pick_still_limit();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom_range(400000);
  endfunction

  function automatic logic [VAR_W-1:0] pick_walk_limit(input logic [VAR_W-1:0] still_max);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1 || still_max == '1) return '1;
    return still_max + $urandom_range(4000000);
  endfunction

  task automatic send_sample(input logic [MAG_W-1:0] mag);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_magnitude <= mag;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // writes all three registers on consecutive cycles; only called with the block idle
  task automatic configure(input logic [WLEN_W-1:0] wlen, input logic [VAR_W-1:0] still_max,
                           input logic [VAR_W-1:0] walk_max);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW_LENGTH;
    cfg_wdata <= CFG_W'(wlen);
    @(posedge clk);
    cfg_index <= CFG_STILL_MAX;
    cfg_wdata <= still_max;
    @(posedge clk);
    cfg_index <= CFG_WALK_MAX;
    cfg_wdata <= walk_max;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input logic [WLEN_W-1:0] wlen, input int unsigned count);
    logic [VAR_W-1:0] still_max;
    still_max = pick_still_limit();
    drain_results();
    configure(wlen, still_max, pick_walk_limit(still_max));
    new_gait();
    calm <= ($urandom_range(4) == 0);
    repeat (count) begin
      if ($urandom_range(59) == 0) drain_results();
      if ($urandom_range(49) == 0) new_gait();
      send_sample(next_magnitude());
    end
  endtask

  initial begin : stimulus
    int p;
    int unsigned r;
    logic [WLEN_W-1:0] wlen;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // one-sample window: first item only fills, next one primes the step detector
    drain_results();
    configure(9'd1, 32'd0, 32'd0);
    send_sample(16'd0);
    send_sample(16'hFFFF);
    send_sample(16'd0);
    send_sample(16'hFFFF);
    // zero length behaves as one
    drain_results();
    configure(9'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(16'hFFFF);
    send_sample(16'd0);
    // two samples: one more fill item, then steps and the exact -200 boundary
    drain_results();
    configure(9'd2, STILL_RESET, WALK_RESET);
    send_sample(16'd1000);
    send_sample(16'd1000);
    send_sample(16'd0);
    send_sample(16'd1000);
    send_sample(16'd0);
    send_sample(16'd1000);
    send_sample(16'd599);
    send_sample(16'd1000);
    send_sample(16'd600);
    // growing the window resumes filling
    drain_results();
    configure(9'd4, 32'd0, 32'hFFFF_FFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'd0);
    send_sample(16'hFFFF);
    // shrinking below the fill level labels at once
    drain_results();
    configure(9'd3, 32'hFFFF_FFFF, 32'd0);
    send_sample(16'd0);
    send_sample(16'hFFFF);
    send_sample(16'd0);

    for (p = 0; p < 15; p++) begin
      r = $urandom_range(9);
      if (r < 7) wlen = WLEN_W'($urandom_range(24, 1));
      else if (r < 9) wlen = WLEN_W'($urandom_range(64, 25));
      else wlen = WLEN_W'($urandom_range(128, 65));
      run_phase(wlen, $urandom_range(45, 30));
    end
    // full store depth, then an oversized length that clamps to it
    run_phase(9'd256, 300);
    run_phase(9'd511, 40);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d samples over %0d register settings, window lengths 0 to 511.",
             samples_sent, settings_used);
    $display("Labels checked: %0d still, %0d walking, %0d running; step total ended at %0d.",
             still_seen, walk_seen, run_seen, last_step_total);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== windowed_activity_classifier.f =====
rtl/wac_pkg.sv
rtl/wac_ctrl.sv
rtl/wac_dp.sv
rtl/windowed_activity_classifier.sv
test/windowed_activity_classifier_checker.sv
test/windowed_activity_classifier_test.sv
